@@ src/jhgc_pkg.sv @@
// ----------------------------------------------------------------------------
// jhgc_pkg: shared types, constants and tables of the Johab glyph composer
// Beat structs, glyph store geometry, component lookup tables and palette.
// ----------------------------------------------------------------------------
package jhgc_pkg;

  localparam int GLYPH_BYTES = 64;
  localparam int GLYPH_ROWS  = 16;
  localparam int ROW_BYTES   = GLYPH_BYTES / GLYPH_ROWS;

  localparam int SET1_COUNT = 191;
  localparam int SET2_COUNT = 85;
  localparam int SET3_COUNT = 109;

  // Each set lives in its own store, one 32-bit word per glyph row.
  localparam int INI_DEPTH = SET1_COUNT * GLYPH_ROWS;
  localparam int MED_DEPTH = SET2_COUNT * GLYPH_ROWS;
  localparam int FIN_DEPTH = SET3_COUNT * GLYPH_ROWS;
  localparam int INI_AW    = 12;
  localparam int MED_AW    = 11;
  localparam int FIN_AW    = 11;

  // First store row of each set in the flat load address space
  localparam logic [12:0] MED_FIRST_ROW = 13'(INI_DEPTH);
  localparam logic [12:0] FIN_FIRST_ROW = 13'(INI_DEPTH + MED_DEPTH);
  localparam logic [12:0] STORE_ROWS    = 13'(INI_DEPTH + MED_DEPTH + FIN_DEPTH);

  localparam logic [7:0] SET1_LIMIT = 8'(SET1_COUNT);
  localparam logic [7:0] SET_SKEW   = 8'd2;
  localparam logic [7:0] SET2_LIMIT = 8'(SET2_COUNT + 2);
  localparam logic [7:0] SET3_LIMIT = 8'(SET3_COUNT + 2);
  localparam logic [3:0] LAST_ROW   = 4'(GLYPH_ROWS - 1);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [14:0] load_address;
    logic [7:0]  load_byte;
    logic [15:0] char_code;
  } cmd_t;

  typedef struct packed {
    logic [63:0] row_pixels;
    logic [3:0]  row_number;
    logic        has_final_consonant;
    logic        last_row;
  } row_t;

  // Decoded components: presence and glyph index local to each set
  typedef struct packed {
    logic       ini_ok;
    logic       med_ok;
    logic       fin_ok;
    logic [7:0] ini_loc;
    logic [6:0] med_loc;
    logic [6:0] fin_loc;
  } glyph_sel_t;

  typedef logic signed [13:0] tval_t;

  localparam logic [3:0] PALETTE [4] = '{4'd0, 4'd2, 4'd4, 4'd11};

  localparam tval_t INI_BASE [32] = '{
    -14'sd1, 14'sd0, 14'sd32, 14'sd352, 14'sd672, 14'sd992, 14'sd1312, 14'sd1632,
    14'sd1952, 14'sd2272, 14'sd2592, 14'sd2912, 14'sd3232, 14'sd3552, 14'sd3872,
    14'sd4192, 14'sd4512, 14'sd4832, 14'sd5152, 14'sd5472, 14'sd5792,
    -14'sd1, -14'sd1, -14'sd1, -14'sd1, -14'sd1, -14'sd1, -14'sd1, -14'sd1,
    -14'sd1, -14'sd1, -14'sd1};

  localparam tval_t MED_BASE [32] = '{
    -14'sd1, -14'sd1, 14'sd0, 14'sd128, 14'sd256, 14'sd384, 14'sd512, 14'sd640,
    -14'sd1, -14'sd1, 14'sd768, 14'sd896, 14'sd1024, 14'sd1152, 14'sd1280, 14'sd1408,
    -14'sd1, -14'sd1, 14'sd1536, 14'sd1664, 14'sd1792, 14'sd1920, 14'sd2048,
    14'sd2176, -14'sd1, -14'sd1, 14'sd2304, 14'sd2432, 14'sd2560, 14'sd2688,
    -14'sd1, -14'sd1};

  localparam tval_t FIN_BASE [32] = '{
    -14'sd1, 14'sd0, 14'sd128, 14'sd256, 14'sd384, 14'sd512, 14'sd640, 14'sd768,
    14'sd896, 14'sd1024, 14'sd1152, 14'sd1280, 14'sd1408, 14'sd1536, 14'sd1664,
    14'sd1792, 14'sd1920, 14'sd2048, -14'sd1, 14'sd2176, 14'sd2304, 14'sd2432,
    14'sd2560, 14'sd2688, 14'sd2816, 14'sd2944, 14'sd3072, 14'sd3200, 14'sd3328,
    14'sd3456, -14'sd1, -14'sd1};

  localparam tval_t MED_BY_INI [32] = '{
    -14'sd1, 14'sd0, 14'sd0, 14'sd64, 14'sd64, 14'sd64, 14'sd64, 14'sd64,
    14'sd64, 14'sd64, 14'sd64, 14'sd64, 14'sd64, 14'sd64, 14'sd64, 14'sd64,
    14'sd64, 14'sd0, 14'sd64, 14'sd64, 14'sd64, -14'sd1, -14'sd1, -14'sd1,
    -14'sd1, -14'sd1, -14'sd1, -14'sd1, -14'sd1, -14'sd1, -14'sd1, -14'sd1};

  localparam tval_t INI_BY_MED [32] = '{
    14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0,
    14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd64, 14'sd192, 14'sd192,
    14'sd0, 14'sd0, 14'sd192, 14'sd64, 14'sd128, 14'sd256, 14'sd256, 14'sd256,
    14'sd0, 14'sd0, 14'sd128, 14'sd64, 14'sd192, 14'sd0, 14'sd0, 14'sd0};

  localparam tval_t FIN_BY_MED [32] = '{
    14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd64, 14'sd0, 14'sd64, 14'sd32,
    14'sd0, 14'sd0, 14'sd64, 14'sd32, 14'sd64, 14'sd96, 14'sd0, 14'sd64,
    14'sd0, 14'sd0, 14'sd32, 14'sd96, 14'sd96, 14'sd32, 14'sd64, 14'sd32,
    14'sd0, 14'sd0, 14'sd96, 14'sd96, 14'sd32, 14'sd32, 14'sd0, 14'sd0};

  localparam tval_t BY_FIN [32] = '{
    -14'sd1, 14'sd0, 14'sd32, 14'sd32, 14'sd32, 14'sd32, 14'sd32, 14'sd32,
    14'sd32, 14'sd32, 14'sd32, 14'sd32, 14'sd32, 14'sd32, 14'sd32, 14'sd32,
    14'sd32, 14'sd32, -14'sd1, 14'sd32, 14'sd32, 14'sd32, 14'sd32, 14'sd32,
    14'sd32, 14'sd32, 14'sd32, 14'sd32, 14'sd32, 14'sd32, -14'sd1, -14'sd1};

endpackage

@@ src/johab_hangul_glyph_composer.sv @@
// ----------------------------------------------------------------------------
// johab_hangul_glyph_composer: 16x16 Hangul character generator
// Composes initial, medial and final component glyphs into pixel rows.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): a load beat writes one packed
//   font byte into the glyph store; a render beat takes a Johab code.
//   row channel (row_valid / row_stall / row): a render returns 16 beats, one
//   glyph row each, top row first, last_row set on row 15. Loads return none.
// Timing:
//   Pipeline is decode -> row issue -> store read -> overlay/output register.
//   A render beat passes the decode, issue, store read and output registers
//   before its first row leaves, then one row per cycle unless row_stall
//   holds. A render holds the issue stage through all 16 rows (one read of
//   each set store per row, one read port each); loads pass one per cycle.
// Reset: clears all valid bits. The store is not cleared; render only glyphs
//   that were loaded.
// Backpressure: while row_stall holds an output beat, every stage but decode
//   freezes; cmd_stall rises once the decode and issue stages are occupied.
// ----------------------------------------------------------------------------
module johab_hangul_glyph_composer (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  jhgc_pkg::cmd_t cmd,
  output logic           row_valid,
  input  logic           row_stall,
  output jhgc_pkg::row_t row
);

  // decode stage
  logic           d_valid;
  jhgc_pkg::cmd_t d_item;
  logic           d_take;
  jhgc_pkg::glyph_sel_t d_sel;

  // issue stage
  logic                 q_valid;
  jhgc_pkg::opcode_t    q_op;
  logic [14:0]          q_addr;
  logic [7:0]           q_byte;
  jhgc_pkg::glyph_sel_t q_sel;
  logic [3:0]           q_row;
  logic                 q_issue;
  logic                 q_end;
  logic [12:0]          q_wrow;

  // store read stage
  logic                 m_valid;
  logic [3:0]           m_row;
  logic                 m_last;
  jhgc_pkg::glyph_sel_t m_sel;
  logic [31:0]          ini_row;
  logic [31:0]          med_row;
  logic [31:0]          fin_row;

  // output stage
  logic           o_valid;
  jhgc_pkg::row_t o_item;
  logic [63:0]    pix;

  logic en;
  logic q_load;
  logic wr_ini;
  logic wr_med;
  logic wr_fin;

  assign en      = !o_valid || !row_stall;
  assign q_issue = q_valid && en;
  assign q_load  = (q_op == jhgc_pkg::OP_LOAD);
  assign q_end   = q_issue && (q_load || q_row == jhgc_pkg::LAST_ROW);
  assign d_take  = d_valid && (!q_valid || q_end);
  assign cmd_stall = d_valid && !d_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      d_valid <= 1'b1;
    end else if (d_take) begin
      d_valid <= 1'b0;
    end
    if (cmd_valid && !cmd_stall) begin
      d_item <= cmd;
    end
  end

  jhgc_decode u_decode (
    .char_code (d_item.char_code),
    .sel       (d_sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (d_take) begin
      q_valid <= 1'b1;
    end else if (q_end) begin
      q_valid <= 1'b0;
    end
    if (d_take) begin
      q_op   <= d_item.opcode;
      q_addr <= d_item.load_address;
      q_byte <= d_item.load_byte;
      q_sel  <= d_sel;
      q_row  <= 4'd0;
    end else if (q_issue) begin
      q_row <= q_row + 4'd1;
    end
  end

  // load address split: store row = address / 4, byte lane = address % 4
  assign q_wrow = q_addr[14:2];
  assign wr_ini = q_issue && q_load && (q_wrow < jhgc_pkg::MED_FIRST_ROW);
  assign wr_med = q_issue && q_load && (q_wrow >= jhgc_pkg::MED_FIRST_ROW) &&
                  (q_wrow < jhgc_pkg::FIN_FIRST_ROW);
  assign wr_fin = q_issue && q_load && (q_wrow >= jhgc_pkg::FIN_FIRST_ROW) &&
                  (q_wrow < jhgc_pkg::STORE_ROWS);

  jhgc_ram #(.DEPTH(jhgc_pkg::INI_DEPTH), .AW(jhgc_pkg::INI_AW)) u_ini_ram (
    .clk     (clk),
    .wr_en   (wr_ini),
    .wr_lane (q_addr[1:0]),
    .wr_addr (q_wrow[jhgc_pkg::INI_AW-1:0]),
    .wr_byte (q_byte),
    .rd_en   (en),
    .rd_addr ({q_sel.ini_loc, q_row}),
    .rd_data (ini_row)
  );

  jhgc_ram #(.DEPTH(jhgc_pkg::MED_DEPTH), .AW(jhgc_pkg::MED_AW)) u_med_ram (
    .clk     (clk),
    .wr_en   (wr_med),
    .wr_lane (q_addr[1:0]),
    .wr_addr (jhgc_pkg::MED_AW'(q_wrow - jhgc_pkg::MED_FIRST_ROW)),
    .wr_byte (q_byte),
    .rd_en   (en),
    .rd_addr ({q_sel.med_loc, q_row}),
    .rd_data (med_row)
  );

  jhgc_ram #(.DEPTH(jhgc_pkg::FIN_DEPTH), .AW(jhgc_pkg::FIN_AW)) u_fin_ram (
    .clk     (clk),
    .wr_en   (wr_fin),
    .wr_lane (q_addr[1:0]),
    .wr_addr (jhgc_pkg::FIN_AW'(q_wrow - jhgc_pkg::FIN_FIRST_ROW)),
    .wr_byte (q_byte),
    .rd_en   (en),
    .rd_addr ({q_sel.fin_loc, q_row}),
    .rd_data (fin_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= q_valid && !q_load;
    end
    if (en) begin
      m_row  <= q_row;
      m_last <= (q_row == jhgc_pkg::LAST_ROW);
      m_sel  <= q_sel;
    end
  end

  jhgc_overlay u_overlay (
    .sel     (m_sel),
    .ini_row (ini_row),
    .med_row (med_row),
    .fin_row (fin_row),
    .pixels  (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= m_valid;
    end
    if (en) begin
      o_item.row_pixels          <= pix;
      o_item.row_number          <= m_row;
      o_item.has_final_consonant <= m_sel.fin_ok;
      o_item.last_row            <= m_last;
    end
  end

  assign row_valid = o_valid;
  assign row       = o_item;

  // rows of one render sit back to back in the output and read stages
  assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_item.last_row) |-> (m_valid && m_row == o_item.row_number + 4'd1))
    else $error("row sequence broken between read and output stage");

  assert property (@(posedge clk) disable iff (rst)
    (d_valid && !d_take) |=> (d_valid && $stable(d_item)))
    else $error("decode stage lost or changed a waiting beat");

  assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_end) |=> (q_valid && $stable(q_sel) && $stable(q_op)))
    else $error("issue stage context changed mid render");

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({wr_ini, wr_med, wr_fin}))
    else $error("load beat wrote more than one set store");

endmodule

@@ src/jhgc_ram.sv @@
// ----------------------------------------------------------------------------
// jhgc_ram: glyph row store
// One 32-bit word per glyph row, byte-lane writes, registered read port.
// Lane 0 is the leftmost byte of the row (bits 31..24).
// ----------------------------------------------------------------------------
module jhgc_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [1:0]    wr_lane,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_byte,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][{~wr_lane, 3'b000} +: 8] <= wr_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/jhgc_decode.sv @@
// ----------------------------------------------------------------------------
// jhgc_decode: Johab code to component glyph selection
// Table lookups on the three 5-bit fields, offset sums and set range checks.
// ----------------------------------------------------------------------------
module jhgc_decode (
  input  logic [15:0]          char_code,
  output jhgc_pkg::glyph_sel_t sel
);

  logic [4:0]      fi;
  logic [4:0]      mi;
  logic [4:0]      li;
  jhgc_pkg::tval_t ini_b;
  jhgc_pkg::tval_t med_b;
  jhgc_pkg::tval_t fin_b;
  jhgc_pkg::tval_t ini_v;
  jhgc_pkg::tval_t med_v;
  jhgc_pkg::tval_t fin_v;
  logic [7:0]      med_q;
  logic [7:0]      fin_q;
  logic            ini_ok;
  logic            med_ok;
  logic            fin_ok;

  assign fi = char_code[14:10];
  assign mi = char_code[9:5];
  assign li = char_code[4:0];

  assign ini_b = jhgc_pkg::INI_BASE[fi];
  assign med_b = jhgc_pkg::MED_BASE[mi];
  assign fin_b = jhgc_pkg::FIN_BASE[li];

  // a zero base (first glyph of a set) takes no variant offset
  assign ini_v = (ini_b > 14'sd0) ?
                 ini_b + jhgc_pkg::INI_BY_MED[mi] + jhgc_pkg::BY_FIN[li] : ini_b;
  assign med_v = med_b + jhgc_pkg::MED_BY_INI[fi] + jhgc_pkg::BY_FIN[li] - 14'sd3;
  assign fin_v = fin_b + jhgc_pkg::FIN_BY_MED[mi] - 14'sd3;

  assign med_q = med_v[12:5];
  assign fin_q = fin_v[12:5];

  assign ini_ok = !ini_v[13] && (ini_v[12:5] < jhgc_pkg::SET1_LIMIT);
  assign med_ok = (med_b > 14'sd0) && !med_v[13] &&
                  (med_q >= jhgc_pkg::SET_SKEW) && (med_q < jhgc_pkg::SET2_LIMIT);
  assign fin_ok = (fin_b > 14'sd0) && !fin_v[13] &&
                  (fin_q >= jhgc_pkg::SET_SKEW) && (fin_q < jhgc_pkg::SET3_LIMIT);

  always_comb begin
    sel.ini_ok  = ini_ok;
    sel.med_ok  = med_ok;
    sel.fin_ok  = fin_ok;
    sel.ini_loc = ini_ok ? ini_v[12:5] : 8'd0;
    sel.med_loc = med_ok ? 7'(med_q - jhgc_pkg::SET_SKEW) : 7'd0;
    sel.fin_loc = fin_ok ? 7'(fin_q - jhgc_pkg::SET_SKEW) : 7'd0;
  end

endmodule

@@ src/jhgc_overlay.sv @@
// ----------------------------------------------------------------------------
// jhgc_overlay: component row merge and palette map
// Later components overwrite earlier ones where their pixel code is nonzero.
// ----------------------------------------------------------------------------
module jhgc_overlay (
  input  jhgc_pkg::glyph_sel_t sel,
  input  logic [31:0]          ini_row,
  input  logic [31:0]          med_row,
  input  logic [31:0]          fin_row,
  output logic [63:0]          pixels
);

  always_comb begin
    logic [1:0] c;
    logic [1:0] ci;
    logic [1:0] cm;
    logic [1:0] cf;
    pixels = '0;
    for (int p = 0; p < 16; p++) begin
      ci = ini_row[31-2*p -: 2];
      cm = med_row[31-2*p -: 2];
      cf = fin_row[31-2*p -: 2];
      c  = 2'd0;
      if (sel.ini_ok && ci != 2'd0) begin
        c = ci;
      end
      if (sel.med_ok && cm != 2'd0) begin
        c = cm;
      end
      if (sel.fin_ok && cf != 2'd0) begin
        c = cf;
      end
      pixels[63-4*p -: 4] = jhgc_pkg::PALETTE[c];
    end
  end

endmodule
